// File: hw/rtl/dctc_pkg.sv
// Shared constants, codes and types of the DRAM command timing checker.
`default_nettype none

package dctc_pkg;

   // Geometry of the checked memory system and width of the cycle count.
   localparam int RANK_COUNT = 2;
   localparam int BANK_COUNT = 8;
   localparam int CYCLE_BITS = 48;

   localparam int RANK_IDX_BITS = (RANK_COUNT > 1) ? $clog2(RANK_COUNT) : 1;
   localparam int BANK_IDX_BITS = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

   // Field widths of the request and response words.
   localparam int CMD_BITS     = 3;
   localparam int RANK_ID_BITS = 1;
   localparam int BANK_ID_BITS = 3;
   localparam int NOW_BITS     = 48;
   localparam int READY_BITS   = 48;

   localparam int REQ_DATA_USED  = RANK_ID_BITS + BANK_ID_BITS + NOW_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_DATA_USED + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((READY_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_BITS = 2;

   // Timing gaps are eight bits each, packed from the lowest byte up.
   localparam int GAP_BITS           = 8;
   localparam int PRECHARGE_REG_BITS = 24;
   localparam int ACTIVATE_REG_BITS  = 24;
   localparam int READ_REG_BITS      = 40;
   localparam int WRITE_REG_BITS     = 32;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 40;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRECHARGE_GAPS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVATE_GAPS  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_GAPS      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_GAPS     = 3'd3;

   // Command codes; anything above the write code is invalid.
   localparam logic [CMD_BITS-1:0] CMD_PRECHARGE = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_ACTIVATE  = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ      = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_WRITE     = 3'd3;

   typedef struct packed {
      logic [PRECHARGE_REG_BITS-1:0] precharge;
      logic [ACTIVATE_REG_BITS-1:0]  activate;
      logic [READ_REG_BITS-1:0]      read;
      logic [WRITE_REG_BITS-1:0]     write;
   } gaps_type;

   // Record of one issued command.
   typedef struct packed {
      logic                     en;
      logic [CMD_BITS-1:0]      cmd;
      logic [RANK_IDX_BITS-1:0] rank;
      logic [BANK_IDX_BITS-1:0] bank;
      logic [CYCLE_BITS-1:0]    stamp;
   } hist_write_type;

   // History seen by the rule logic for the rank and bank being looked up.
   typedef struct packed {
      logic [BANK_COUNT-1:0][CYCLE_BITS-1:0] act_time;
      logic [BANK_COUNT-1:0]                 act_valid;
      logic [CYCLE_BITS-1:0]                 pre_time;
      logic                                  pre_valid;
      logic [CYCLE_BITS-1:0]                 rd_time;
      logic                                  rd_valid;
      logic [CYCLE_BITS-1:0]                 wr_time;
      logic                                  wr_valid;
      logic [RANK_COUNT-1:0][CYCLE_BITS-1:0] rank_rd_time;
      logic [RANK_COUNT-1:0]                 rank_rd_valid;
      logic [RANK_COUNT-1:0][CYCLE_BITS-1:0] rank_wr_time;
      logic [RANK_COUNT-1:0]                 rank_wr_valid;
   } hist_view_type;

   typedef struct packed {
      logic [CYCLE_BITS-1:0] ready_cycle;
      logic                  issued;
      logic                  bad_command;
   } check_result_type;

endpackage

`default_nettype wire

// File: hw/rtl/dctc_history.sv
// Issue history: last command times per bank and per rank, with valid bits.
`default_nettype none

module dctc_history (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [dctc_pkg::RANK_IDX_BITS-1:0] look_rank,
   input  wire logic [dctc_pkg::BANK_IDX_BITS-1:0] look_bank,
   input  wire dctc_pkg::hist_write_type          hist_wr,
   output dctc_pkg::hist_view_type                hist_view
);
   import dctc_pkg::*;

   // Times per rank and bank, one array per command kind.
   logic [CYCLE_BITS-1:0] act_time_ff [RANK_COUNT][BANK_COUNT];
   logic [CYCLE_BITS-1:0] pre_time_ff [RANK_COUNT][BANK_COUNT];
   logic [CYCLE_BITS-1:0] rd_time_ff  [RANK_COUNT][BANK_COUNT];
   logic [CYCLE_BITS-1:0] wr_time_ff  [RANK_COUNT][BANK_COUNT];
   logic [CYCLE_BITS-1:0] rank_rd_time_ff [RANK_COUNT];
   logic [CYCLE_BITS-1:0] rank_wr_time_ff [RANK_COUNT];

   logic [RANK_COUNT-1:0][BANK_COUNT-1:0] act_valid_ff, act_valid_in;
   logic [RANK_COUNT-1:0][BANK_COUNT-1:0] pre_valid_ff, pre_valid_in;
   logic [RANK_COUNT-1:0][BANK_COUNT-1:0] rd_valid_ff, rd_valid_in;
   logic [RANK_COUNT-1:0][BANK_COUNT-1:0] wr_valid_ff, wr_valid_in;
   logic [RANK_COUNT-1:0] rank_rd_valid_ff, rank_rd_valid_in;
   logic [RANK_COUNT-1:0] rank_wr_valid_ff, rank_wr_valid_in;

   // Next state of the valid bits: set the entry that an issued command writes.
   always_comb begin
      act_valid_in     = act_valid_ff;
      pre_valid_in     = pre_valid_ff;
      rd_valid_in      = rd_valid_ff;
      wr_valid_in      = wr_valid_ff;
      rank_rd_valid_in = rank_rd_valid_ff;
      rank_wr_valid_in = rank_wr_valid_ff;
      if (hist_wr.en) begin
         unique case (hist_wr.cmd)
            CMD_PRECHARGE: pre_valid_in[hist_wr.rank][hist_wr.bank] = 1'b1;
            CMD_ACTIVATE:  act_valid_in[hist_wr.rank][hist_wr.bank] = 1'b1;
            CMD_READ: begin
               rd_valid_in[hist_wr.rank][hist_wr.bank] = 1'b1;
               rank_rd_valid_in[hist_wr.rank]          = 1'b1;
            end
            CMD_WRITE: begin
               wr_valid_in[hist_wr.rank][hist_wr.bank] = 1'b1;
               rank_wr_valid_in[hist_wr.rank]          = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Valid bits clear at reset so that unwritten entries impose no limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff     <= '0;
         pre_valid_ff     <= '0;
         rd_valid_ff      <= '0;
         wr_valid_ff      <= '0;
         rank_rd_valid_ff <= '0;
         rank_wr_valid_ff <= '0;
      end else begin
         act_valid_ff     <= act_valid_in;
         pre_valid_ff     <= pre_valid_in;
         rd_valid_ff      <= rd_valid_in;
         wr_valid_ff      <= wr_valid_in;
         rank_rd_valid_ff <= rank_rd_valid_in;
         rank_wr_valid_ff <= rank_wr_valid_in;
      end
   end

   // Time stamps carry no reset; they are only read behind a valid bit.
   always_ff @(posedge clock) begin
      if (hist_wr.en) begin
         unique case (hist_wr.cmd)
            CMD_PRECHARGE: pre_time_ff[hist_wr.rank][hist_wr.bank] <= hist_wr.stamp;
            CMD_ACTIVATE:  act_time_ff[hist_wr.rank][hist_wr.bank] <= hist_wr.stamp;
            CMD_READ: begin
               rd_time_ff[hist_wr.rank][hist_wr.bank] <= hist_wr.stamp;
               rank_rd_time_ff[hist_wr.rank]          <= hist_wr.stamp;
            end
            CMD_WRITE: begin
               wr_time_ff[hist_wr.rank][hist_wr.bank] <= hist_wr.stamp;
               rank_wr_time_ff[hist_wr.rank]          <= hist_wr.stamp;
            end
            default: ;
         endcase
      end
   end

   // Present every bank's activate time of the looked-up rank, the own bank's
   // other times and the read and write times of all ranks.
   always_comb begin
      for (int b = 0; b < BANK_COUNT; b++) begin
         hist_view.act_time[b]  = act_time_ff[look_rank][b];
         hist_view.act_valid[b] = act_valid_ff[look_rank][b];
      end
      hist_view.pre_time  = pre_time_ff[look_rank][look_bank];
      hist_view.pre_valid = pre_valid_ff[look_rank][look_bank];
      hist_view.rd_time   = rd_time_ff[look_rank][look_bank];
      hist_view.rd_valid  = rd_valid_ff[look_rank][look_bank];
      hist_view.wr_time   = wr_time_ff[look_rank][look_bank];
      hist_view.wr_valid  = wr_valid_ff[look_rank][look_bank];
      for (int r = 0; r < RANK_COUNT; r++) begin
         hist_view.rank_rd_time[r] = rank_rd_time_ff[r];
         hist_view.rank_wr_time[r] = rank_wr_time_ff[r];
      end
      hist_view.rank_rd_valid = rank_rd_valid_ff;
      hist_view.rank_wr_valid = rank_wr_valid_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/dctc_rules.sv
// Timing rule evaluation: earliest legal cycle and the issue decision.
`default_nettype none

module dctc_rules (
   input  wire logic [dctc_pkg::CMD_BITS-1:0]     cmd,
   input  wire logic [dctc_pkg::RANK_ID_BITS-1:0] rank_id,
   input  wire logic [dctc_pkg::BANK_ID_BITS-1:0] bank_id,
   input  wire logic [dctc_pkg::CYCLE_BITS-1:0]   now_cycle,
   input  wire dctc_pkg::gaps_type                gaps,
   input  wire dctc_pkg::hist_view_type           hist_view,
   output dctc_pkg::check_result_type             result
);
   import dctc_pkg::*;

   // Candidate slots: now, one per bank, two own-bank extras, two per rank.
   localparam int SLOT_COUNT  = 1 + BANK_COUNT + 2 + 2 * RANK_COUNT;
   localparam int TREE_LEVELS = $clog2(SLOT_COUNT);
   localparam int TREE_SIZE   = 1 << TREE_LEVELS;
   localparam int OWN_SLOT    = 1 + BANK_COUNT;
   localparam int RANK_SLOT   = OWN_SLOT + 2;

   logic [RANK_IDX_BITS-1:0] rank_idx;
   logic [BANK_IDX_BITS-1:0] bank_idx;
   logic                     bad;
   logic                     is_pre, is_act, is_rd, is_wr;
   logic                     slot_en   [TREE_SIZE];
   logic [CYCLE_BITS-1:0]    slot_time [TREE_SIZE];
   logic [GAP_BITS-1:0]      slot_gap  [TREE_SIZE];
   logic [CYCLE_BITS-1:0]    node      [2*TREE_SIZE];

   // Last time plus gap, held at the largest cycle value on overflow.
   function automatic logic [CYCLE_BITS-1:0] sat_add(input logic [CYCLE_BITS-1:0] t,
                                                     input logic [GAP_BITS-1:0] g);
      logic [CYCLE_BITS:0] sum;
      sum = {1'b0, t} + (CYCLE_BITS + 1)'(g);
      return sum[CYCLE_BITS] ? {CYCLE_BITS{1'b1}} : sum[CYCLE_BITS-1:0];
   endfunction

   function automatic logic [GAP_BITS-1:0] gap_of(input logic [READ_REG_BITS-1:0] reg_value,
                                                  input int n);
      return reg_value[GAP_BITS*n +: GAP_BITS];
   endfunction

   assign rank_idx = RANK_IDX_BITS'(rank_id);
   assign bank_idx = BANK_IDX_BITS'(bank_id);

   // Command decode and range check.
   always_comb begin
      bad = (cmd > CMD_WRITE) || (32'(rank_id) >= 32'(RANK_COUNT))
            || (32'(bank_id) >= 32'(BANK_COUNT));
      is_pre = !bad && (cmd == CMD_PRECHARGE);
      is_act = !bad && (cmd == CMD_ACTIVATE);
      is_rd  = !bad && (cmd == CMD_READ);
      is_wr  = !bad && (cmd == CMD_WRITE);
   end

   // Fill the candidate slots with the rules that apply to this command.
   always_comb begin
      for (int i = 0; i < TREE_SIZE; i++) begin
         slot_en[i]   = 1'b0;
         slot_time[i] = '0;
         slot_gap[i]  = '0;
      end

      // Activate history of every bank in the target rank.
      for (int b = 0; b < BANK_COUNT; b++) begin
         slot_time[1+b] = hist_view.act_time[b];
         if (BANK_IDX_BITS'(b) == bank_idx) begin
            slot_en[1+b] = hist_view.act_valid[b] && !bad;
            if (is_pre) begin
               slot_gap[1+b] = gap_of(READ_REG_BITS'(gaps.precharge), 0);
            end else if (is_act) begin
               slot_gap[1+b] = gap_of(READ_REG_BITS'(gaps.activate), 0);
            end else if (is_rd) begin
               slot_gap[1+b] = gap_of(gaps.read, 0);
            end else begin
               slot_gap[1+b] = gap_of(READ_REG_BITS'(gaps.write), 0);
            end
         end else begin
            slot_en[1+b]  = hist_view.act_valid[b] && is_act;
            slot_gap[1+b] = gap_of(READ_REG_BITS'(gaps.activate), 2);
         end
      end

      // Same-bank rules on precharge, read and write history.
      if (is_pre) begin
         slot_en[OWN_SLOT]     = hist_view.rd_valid;
         slot_time[OWN_SLOT]   = hist_view.rd_time;
         slot_gap[OWN_SLOT]    = gap_of(READ_REG_BITS'(gaps.precharge), 1);
         slot_en[OWN_SLOT+1]   = hist_view.wr_valid;
         slot_time[OWN_SLOT+1] = hist_view.wr_time;
         slot_gap[OWN_SLOT+1]  = gap_of(READ_REG_BITS'(gaps.precharge), 2);
      end else if (is_act) begin
         slot_en[OWN_SLOT]     = hist_view.pre_valid;
         slot_time[OWN_SLOT]   = hist_view.pre_time;
         slot_gap[OWN_SLOT]    = gap_of(READ_REG_BITS'(gaps.activate), 1);
      end

      // Rank-level read and write rules, same rank and other ranks.
      for (int r = 0; r < RANK_COUNT; r++) begin
         slot_time[RANK_SLOT+2*r]   = hist_view.rank_rd_time[r];
         slot_time[RANK_SLOT+2*r+1] = hist_view.rank_wr_time[r];
         slot_en[RANK_SLOT+2*r]     = hist_view.rank_rd_valid[r] && (is_rd || is_wr);
         slot_en[RANK_SLOT+2*r+1]   = hist_view.rank_wr_valid[r] && (is_rd || is_wr);
         if (RANK_IDX_BITS'(r) == rank_idx) begin
            if (is_rd) begin
               slot_gap[RANK_SLOT+2*r]   = gap_of(gaps.read, 1);
               slot_gap[RANK_SLOT+2*r+1] = gap_of(gaps.read, 2);
            end else begin
               slot_gap[RANK_SLOT+2*r]   = gap_of(READ_REG_BITS'(gaps.write), 3);
               slot_gap[RANK_SLOT+2*r+1] = gap_of(READ_REG_BITS'(gaps.write), 1);
            end
         end else begin
            if (is_rd) begin
               slot_gap[RANK_SLOT+2*r]   = gap_of(gaps.read, 3);
               slot_gap[RANK_SLOT+2*r+1] = gap_of(gaps.read, 4);
            end else begin
               slot_gap[RANK_SLOT+2*r]   = gap_of(READ_REG_BITS'(gaps.write), 3);
               slot_gap[RANK_SLOT+2*r+1] = gap_of(READ_REG_BITS'(gaps.write), 2);
            end
         end
      end
   end

   // Saturating adds into the leaves, then a balanced maximum tree.
   always_comb begin
      for (int i = 0; i < TREE_SIZE; i++) begin
         node[i] = '0;
         node[TREE_SIZE+i] = slot_en[i] ? sat_add(slot_time[i], slot_gap[i]) : '0;
      end
      node[TREE_SIZE] = now_cycle;
      for (int n = TREE_SIZE - 1; n >= 1; n--) begin
         node[n] = (node[2*n] > node[2*n+1]) ? node[2*n] : node[2*n+1];
      end
   end

   // A command issues when no rule pushes it past the current cycle.
   always_comb begin
      result.bad_command = bad;
      result.ready_cycle = bad ? '0 : node[1];
      result.issued      = !bad && (node[1] <= now_cycle);
   end

endmodule

`default_nettype wire

// File: hw/rtl/dram_command_timing_checker.sv
// Top level of the DRAM command timing checker: channels, registers and history.
//
// Usage. Candidate commands arrive as words on the req_ stream: req_tuser holds
// the command code, req_tdata the rank, bank and current cycle. For every word
// one response word leaves on the rsp_ stream with the earliest legal cycle in
// rsp_tdata and the issued and bad-command flags in rsp_tuser. An issued
// command is recorded in the history at once, so the next word already sees it.
// Timing gaps are written through the csr_ port, which is always ready; they
// should only change while no word is in flight.
// A word is held in the input register while it is checked, and its response
// then in the response register.
// Throughput: one word per cycle while responses are taken. The check sits
// between the input register and the response register; history is read and
// updated in that same cycle. Reset clears the flow control, the gap registers
// and all history valid bits, so no earlier command limits anything. When the
// receiver stalls, the response register holds and the input register still
// takes one more word; the request side then stalls until the response is taken.
`default_nettype none

module dram_command_timing_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request words.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: rank_id, bank_id, now_cycle, zero fill.
   input  wire logic [dctc_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // Fields from bit 0: cmd.
   input  wire logic [dctc_pkg::CMD_BITS-1:0]       req_tuser,
   // Response words.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Fields from bit 0: ready_cycle.
   output logic [dctc_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata,
   // Fields from bit 0: issued, bad_command.
   output logic [dctc_pkg::RSP_TUSER_BITS-1:0]      rsp_tuser,
   // Configuration writes.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dctc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [dctc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dctc_pkg::*;

   gaps_type gaps_ff, gaps_in;

   logic                    in_valid_ff, in_valid_in;
   logic [CMD_BITS-1:0]     in_cmd_ff;
   logic [RANK_ID_BITS-1:0] in_rank_ff;
   logic [BANK_ID_BITS-1:0] in_bank_ff;
   logic [NOW_BITS-1:0]     in_now_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [READY_BITS-1:0]   rsp_ready_cycle_ff;
   logic                    rsp_issued_ff;
   logic                    rsp_bad_ff;

   logic                    req_accept;
   logic                    advance;
   logic [CYCLE_BITS-1:0]   now_cyc;
   check_result_type        result;
   hist_write_type          hist_wr;
   hist_view_type           hist_view;

   // Gap registers; an index beyond the list is ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      gaps_in = gaps_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRECHARGE_GAPS: gaps_in.precharge = csr_data[PRECHARGE_REG_BITS-1:0];
            CSR_ACTIVATE_GAPS:  gaps_in.activate  = csr_data[ACTIVATE_REG_BITS-1:0];
            CSR_READ_GAPS:      gaps_in.read      = csr_data[READ_REG_BITS-1:0];
            CSR_WRITE_GAPS:     gaps_in.write     = csr_data[WRITE_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gaps_ff <= '0;
      end else begin
         gaps_ff <= gaps_in;
      end
   end

   // Flow control: the input word moves on whenever the response slot is free
   // or being emptied in this cycle.
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= req_tuser;
         in_rank_ff <= req_tdata[RANK_ID_BITS-1:0];
         in_bank_ff <= req_tdata[RANK_ID_BITS +: BANK_ID_BITS];
         in_now_ff  <= req_tdata[RANK_ID_BITS+BANK_ID_BITS +: NOW_BITS];
      end
   end

   assign now_cyc = CYCLE_BITS'(in_now_ff);

   // History of issued commands.
   dctc_history u_history (
      .clock     (clock),
      .reset     (reset),
      .look_rank (RANK_IDX_BITS'(in_rank_ff)),
      .look_bank (BANK_IDX_BITS'(in_bank_ff)),
      .hist_wr   (hist_wr),
      .hist_view (hist_view)
   );

   // Rule check on the registered word.
   dctc_rules u_rules (
      .cmd       (in_cmd_ff),
      .rank_id   (in_rank_ff),
      .bank_id   (in_bank_ff),
      .now_cycle (now_cyc),
      .gaps      (gaps_ff),
      .hist_view (hist_view),
      .result    (result)
   );

   // An issued command is recorded as its response is registered.
   always_comb begin
      hist_wr.en    = advance && result.issued;
      hist_wr.cmd   = in_cmd_ff;
      hist_wr.rank  = RANK_IDX_BITS'(in_rank_ff);
      hist_wr.bank  = BANK_IDX_BITS'(in_bank_ff);
      hist_wr.stamp = now_cyc;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ready_cycle_ff <= READY_BITS'(result.ready_cycle);
         rsp_issued_ff      <= result.issued;
         rsp_bad_ff         <= result.bad_command;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(rsp_ready_cycle_ff);
   assign rsp_tuser  = {rsp_bad_ff, rsp_issued_ff};

endmodule

`default_nettype wire

// File: test/tb_dram_command_timing_checker.sv
// Self-checking testbench for the DRAM command timing checker.
module tb_dram_command_timing_checker;
   timeunit 1ns;
   timeprecision 1ps;

   import dctc_pkg::*;

   localparam int HOLD_CYCLES     = 150;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASE_COUNT     = 6;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;
   localparam int DRAIN_CYCLES    = 8;

   localparam logic [CYCLE_BITS-1:0]     CYCLE_MAX       = '1;
   localparam logic [CMD_BITS-1:0]       CMD_BAD_LOW     = 3'd4;
   localparam logic [CMD_BITS-1:0]       CMD_BAD_TOP     = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_FIRST = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LAST  = 3'd7;
   localparam logic [CSR_DATA_BITS-1:0]  GAPS_ALL_MAX    = '1;
   localparam logic [CSR_DATA_BITS-1:0]  GAPS_NONE       = '0;

   // Per-bank history slots and per-rank history directions.
   typedef enum logic [1:0] {SLOT_ACT, SLOT_PRE, SLOT_RD, SLOT_WR} bank_slot_type;
   localparam int DIR_RD = 0;
   localparam int DIR_WR = 1;

   // One row of the directed sequence: a register write or a command word.
   typedef struct packed {
      logic                      is_csr;
      logic [CMD_BITS-1:0]       code;
      logic                      rank;
      logic [BANK_ID_BITS-1:0]   bank;
      logic [CYCLE_BITS-1:0]     now;
      logic [CSR_DATA_BITS-1:0]  value;
      logic                      typed;
      check_result_type          want;
   } step_row_type;

   localparam step_row_type DIRECTED_STEPS [25] = '{
      // Fresh history with zero gaps: every valid command issues at once.
      '{1'b0, CMD_PRECHARGE, 1'b0, 3'd0, 48'd0, '0, 1'b1, '{48'd0, 1'b1, 1'b0}},
      '{1'b0, CMD_BAD_TOP, 1'b1, 3'd7, CYCLE_MAX, '0, 1'b1, '{48'd0, 1'b0, 1'b1}},
      '{1'b0, CMD_BAD_LOW, 1'b0, 3'd0, 48'd5, '0, 1'b1, '{48'd0, 1'b0, 1'b1}},
      '{1'b0, CMD_ACTIVATE, 1'b1, 3'd7, CYCLE_MAX, '0, 1'b1, '{CYCLE_MAX, 1'b1, 1'b0}},
      '{1'b0, CMD_READ, 1'b0, 3'd3, 48'd10, '0, 1'b0, '0},
      '{1'b0, CMD_WRITE, 1'b1, 3'd5, 48'd11, '0, 1'b0, '0},
      // Largest gaps everywhere, with the unused upper bits set as well.
      '{1'b1, CSR_PRECHARGE_GAPS, 1'b0, 3'd0, '0, GAPS_ALL_MAX, 1'b0, '0},
      '{1'b1, CSR_ACTIVATE_GAPS, 1'b0, 3'd0, '0, GAPS_ALL_MAX, 1'b0, '0},
      '{1'b1, CSR_READ_GAPS, 1'b0, 3'd0, '0, GAPS_ALL_MAX, 1'b0, '0},
      '{1'b1, CSR_WRITE_GAPS, 1'b0, 3'd0, '0, GAPS_ALL_MAX, 1'b0, '0},
      '{1'b1, CSR_SPARE_FIRST, 1'b0, 3'd0, '0, 40'h5A_A55A_A55A, 1'b0, '0},
      '{1'b0, CMD_ACTIVATE, 1'b0, 3'd0, 48'd100, '0, 1'b0, '0},
      '{1'b0, CMD_ACTIVATE, 1'b0, 3'd0, 48'd255, '0, 1'b0, '0},
      '{1'b0, CMD_READ, 1'b0, 3'd0, 48'd256, '0, 1'b0, '0},
      '{1'b0, CMD_READ, 1'b0, 3'd0, 48'd510, '0, 1'b0, '0},
      '{1'b0, CMD_WRITE, 1'b0, 3'd0, 48'd600, '0, 1'b0, '0},
      // Near the top of the cycle range the sums saturate.
      '{1'b0, CMD_PRECHARGE, 1'b0, 3'd0, CYCLE_MAX - 48'd15, '0, 1'b0, '0},
      '{1'b0, CMD_ACTIVATE, 1'b0, 3'd0, CYCLE_MAX - 48'd14, '0, 1'b1, '{CYCLE_MAX, 1'b0, 1'b0}},
      '{1'b0, CMD_ACTIVATE, 1'b0, 3'd0, CYCLE_MAX, '0, 1'b1, '{CYCLE_MAX, 1'b1, 1'b0}},
      '{1'b0, CMD_READ, 1'b1, 3'd7, CYCLE_MAX, '0, 1'b0, '0},
      // Time running backwards is not caught, the rules simply apply.
      '{1'b0, CMD_WRITE, 1'b1, 3'd7, 48'd3, '0, 1'b0, '0},
      '{1'b1, CSR_PRECHARGE_GAPS, 1'b0, 3'd0, '0, GAPS_NONE, 1'b0, '0},
      '{1'b1, CSR_ACTIVATE_GAPS, 1'b0, 3'd0, '0, GAPS_NONE, 1'b0, '0},
      '{1'b1, CSR_READ_GAPS, 1'b0, 3'd0, '0, GAPS_NONE, 1'b0, '0},
      '{1'b1, CSR_WRITE_GAPS, 1'b0, 3'd0, '0, GAPS_NONE, 1'b0, '0}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic [CMD_BITS-1:0]       req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   // Shadow of the gap registers and the command history.
   logic [CSR_DATA_BITS-1:0] pre_gap_set, act_gap_set, rd_gap_set, wr_gap_set;
   logic [CYCLE_BITS-1:0]    bank_stamp [RANK_COUNT][BANK_COUNT][4];
   bit                       bank_seen  [RANK_COUNT][BANK_COUNT][4];
   logic [CYCLE_BITS-1:0]    rank_stamp [RANK_COUNT][2];
   bit                       rank_seen  [RANK_COUNT][2];

   check_result_type verdicts_due [$];
   int               mismatches;
   int               cycle_count;
   int               hold_requests;
   int               hold_served;
   bit               holding;
   bit               steady_sender;

   dram_command_timing_checker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [GAP_BITS-1:0] gap_field(logic [CSR_DATA_BITS-1:0] setting, int n);
      return setting[GAP_BITS*n +: GAP_BITS];
   endfunction

   // A recorded time plus a gap, held at the top of the cycle range.
   function automatic logic [CYCLE_BITS-1:0] plus_gap(logic [CYCLE_BITS-1:0] stamp,
                                                      logic [GAP_BITS-1:0] gap);
      logic [CYCLE_BITS:0] sum;
      sum = {1'b0, stamp} + (CYCLE_BITS+1)'(gap);
      return sum[CYCLE_BITS] ? CYCLE_MAX : sum[CYCLE_BITS-1:0];
   endfunction

   // Pushes the ready cycle out by one rule, if its history entry exists.
   function automatic logic [CYCLE_BITS-1:0] later_of(logic [CYCLE_BITS-1:0] ready, bit seen,
                                                      logic [CYCLE_BITS-1:0] stamp,
                                                      logic [GAP_BITS-1:0] gap);
      logic [CYCLE_BITS-1:0] limit;
      if (!seen)
         return ready;
      limit = plus_gap(stamp, gap);
      return (limit > ready) ? limit : ready;
   endfunction

   // Earliest legal cycle of a command against the current history.
   function automatic check_result_type earliest_issue(logic [CMD_BITS-1:0] cmd, logic rank,
                                                       logic [BANK_ID_BITS-1:0] bank,
                                                       logic [CYCLE_BITS-1:0] now);
      check_result_type      verdict;
      logic [CYCLE_BITS-1:0] ready;
      int                    other;
      verdict = '0;
      if (cmd > CMD_WRITE || int'(rank) >= RANK_COUNT || int'(bank) >= BANK_COUNT) begin
         verdict.bad_command = 1'b1;
         return verdict;
      end
      ready = now;
      case (cmd)
         CMD_PRECHARGE: begin
            ready = later_of(ready, bank_seen[rank][bank][SLOT_ACT],
                             bank_stamp[rank][bank][SLOT_ACT], gap_field(pre_gap_set, 0));
            ready = later_of(ready, bank_seen[rank][bank][SLOT_RD],
                             bank_stamp[rank][bank][SLOT_RD], gap_field(pre_gap_set, 1));
            ready = later_of(ready, bank_seen[rank][bank][SLOT_WR],
                             bank_stamp[rank][bank][SLOT_WR], gap_field(pre_gap_set, 2));
         end
         CMD_ACTIVATE: begin
            ready = later_of(ready, bank_seen[rank][bank][SLOT_ACT],
                             bank_stamp[rank][bank][SLOT_ACT], gap_field(act_gap_set, 0));
            ready = later_of(ready, bank_seen[rank][bank][SLOT_PRE],
                             bank_stamp[rank][bank][SLOT_PRE], gap_field(act_gap_set, 1));
            for (other = 0; other < BANK_COUNT; other++)
               if (other != int'(bank))
                  ready = later_of(ready, bank_seen[rank][other][SLOT_ACT],
                                   bank_stamp[rank][other][SLOT_ACT], gap_field(act_gap_set, 2));
         end
         CMD_READ: begin
            ready = later_of(ready, bank_seen[rank][bank][SLOT_ACT],
                             bank_stamp[rank][bank][SLOT_ACT], gap_field(rd_gap_set, 0));
            for (other = 0; other < RANK_COUNT; other++) begin
               ready = later_of(ready, rank_seen[other][DIR_RD], rank_stamp[other][DIR_RD],
                                gap_field(rd_gap_set, (other == int'(rank)) ? 1 : 3));
               ready = later_of(ready, rank_seen[other][DIR_WR], rank_stamp[other][DIR_WR],
                                gap_field(rd_gap_set, (other == int'(rank)) ? 2 : 4));
            end
         end
         default: begin
            ready = later_of(ready, bank_seen[rank][bank][SLOT_ACT],
                             bank_stamp[rank][bank][SLOT_ACT], gap_field(wr_gap_set, 0));
            for (other = 0; other < RANK_COUNT; other++) begin
               ready = later_of(ready, rank_seen[other][DIR_WR], rank_stamp[other][DIR_WR],
                                gap_field(wr_gap_set, (other == int'(rank)) ? 1 : 2));
               ready = later_of(ready, rank_seen[other][DIR_RD], rank_stamp[other][DIR_RD],
                                gap_field(wr_gap_set, 3));
            end
         end
      endcase
      verdict.ready_cycle = ready;
      verdict.issued      = (ready <= now);
      return verdict;
   endfunction

   // An issued command leaves its time in the bank history, and in the rank
   // history for reads and writes.
   function automatic void record_command(logic [CMD_BITS-1:0] cmd, logic rank,
                                          logic [BANK_ID_BITS-1:0] bank,
                                          logic [CYCLE_BITS-1:0] now);
      bank_slot_type slot;
      case (cmd)
         CMD_PRECHARGE: slot = SLOT_PRE;
         CMD_ACTIVATE:  slot = SLOT_ACT;
         CMD_READ:      slot = SLOT_RD;
         default:       slot = SLOT_WR;
      endcase
      bank_stamp[rank][bank][slot] = now;
      bank_seen[rank][bank][slot]  = 1'b1;
      if (cmd == CMD_READ) begin
         rank_stamp[rank][DIR_RD] = now;
         rank_seen[rank][DIR_RD]  = 1'b1;
      end else if (cmd == CMD_WRITE) begin
         rank_stamp[rank][DIR_WR] = now;
         rank_seen[rank][DIR_WR]  = 1'b1;
      end
   endfunction

   function automatic logic [CYCLE_BITS-1:0] random_cycle();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return bits[CYCLE_BITS-1:0];
   endfunction

   // Either short gaps in every byte, so that retries come quickly, or any value.
   function automatic logic [CSR_DATA_BITS-1:0] pick_gaps(bit narrow);
      logic [63:0]              bits;
      logic [CSR_DATA_BITS-1:0] setting;
      bits    = {$urandom(), $urandom()};
      setting = bits[CSR_DATA_BITS-1:0];
      if (narrow)
         for (int n = 0; n < CSR_DATA_BITS / GAP_BITS; n++)
            setting[GAP_BITS*n +: GAP_BITS] = GAP_BITS'($urandom_range(0, 15));
      return setting;
   endfunction

   // Register write; the request side is quiet and every response is home.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (index)
         CSR_PRECHARGE_GAPS: pre_gap_set = CSR_DATA_BITS'(value[PRECHARGE_REG_BITS-1:0]);
         CSR_ACTIVATE_GAPS:  act_gap_set = CSR_DATA_BITS'(value[ACTIVATE_REG_BITS-1:0]);
         CSR_READ_GAPS:      rd_gap_set  = CSR_DATA_BITS'(value[READ_REG_BITS-1:0]);
         CSR_WRITE_GAPS:     wr_gap_set  = CSR_DATA_BITS'(value[WRITE_REG_BITS-1:0]);
         default: ;
      endcase
   endtask

   // Offers one command word, maybe after an idle gap, and books its verdict
   // once the word is taken.
   task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic rank,
                            input logic [BANK_ID_BITS-1:0] bank,
                            input logic [CYCLE_BITS-1:0] now, input bit typed,
                            input check_result_type typed_want,
                            output check_result_type outcome);
      int pause;
      pause = 0;
      // A register write that has just gone through is not offered again.
      csr_valid <= 1'b0;
      if (!steady_sender && !holding && $urandom_range(0, 99) < 30)
         pause = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_TDATA_BITS'({now, bank, rank});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      outcome = earliest_issue(cmd, rank, bank, now);
      if (outcome.issued)
         record_command(cmd, rank, bank, now);
      verdicts_due.push_back(typed ? typed_want : outcome);
   endtask

   // Command source: directed rows, then phases of scheduler-like traffic.
   initial begin : command_source
      step_row_type          row;
      check_result_type      outcome;
      logic [CYCLE_BITS-1:0] clock_now;
      logic [CMD_BITS-1:0]   retry_cmd;
      logic                  retry_rank;
      logic [BANK_ID_BITS-1:0] retry_bank;
      logic [CYCLE_BITS-1:0] retry_at;
      bit                    retry_open;
      int                    pick;

      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      mismatches    = 0;
      hold_requests = 0;
      steady_sender = 1'b0;
      pre_gap_set   = '0;
      act_gap_set   = '0;
      rd_gap_set    = '0;
      wr_gap_set    = '0;
      clock_now     = '0;
      retry_open    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
         row = DIRECTED_STEPS[i];
         if (row.is_csr)
            write_register(row.code, row.value);
         else
            send_word(row.code, row.rank, row.bank, row.now, row.typed, row.want, outcome);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_register(CSR_PRECHARGE_GAPS, pick_gaps(phase % 2 == 0));
         write_register(CSR_ACTIVATE_GAPS, pick_gaps(phase % 2 == 0));
         write_register(CSR_READ_GAPS, pick_gaps(phase % 2 == 0));
         write_register(CSR_WRITE_GAPS, pick_gaps(phase % 2 == 0));
         write_register(CSR_INDEX_BITS'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                        pick_gaps(1'b0));
         steady_sender = (phase % 3 == 2);
         // Close to the top of the cycle range, so that sums saturate and wrap.
         if (phase == 4)
            clock_now = CYCLE_MAX - 48'd3000;
         // Stall the receiver for a long stretch so the block backs up.
         if (phase == 1 || phase == 4)
            hold_requests++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               send_word(CMD_BITS'($urandom_range(CMD_BAD_LOW, CMD_BAD_TOP)),
                         1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                         random_cycle(), 1'b0, '0, outcome);
            end else if (pick < 10) begin
               send_word(CMD_BITS'($urandom_range(CMD_PRECHARGE, CMD_WRITE)),
                         1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                         random_cycle(), 1'b0, '0, outcome);
            end else begin
               // A refused command is mostly tried again at its ready cycle.
               if (!(retry_open && pick < 60)) begin
                  retry_cmd  = CMD_BITS'($urandom_range(CMD_PRECHARGE, CMD_WRITE));
                  retry_rank = 1'($urandom_range(0, 1));
                  retry_bank = 3'($urandom_range(0, 7));
                  clock_now  = clock_now + CYCLE_BITS'($urandom_range(0, 5));
               end else if (retry_at > clock_now) begin
                  clock_now = retry_at;
               end
               send_word(retry_cmd, retry_rank, retry_bank, clock_now, 1'b0, '0, outcome);
               retry_open = !outcome.issued;
               retry_at   = outcome.ready_cycle;
            end
         end
      end

      // Let every response drain, then a few quiet cycles.
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Response sink: random stalls, calm windows and the long hold-off.
   initial begin : response_sink
      int stall_left;
      int window_left;
      bit calm;
      rsp_tready  <= 1'b0;
      hold_served = 0;
      holding     = 1'b0;
      stall_left  = 0;
      window_left = 0;
      calm        = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            holding     = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding = 1'b0;
         end
         if (window_left == 0) begin
            window_left = 100;
            calm        = ($urandom_range(0, 2) == 0);
         end
         window_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end
      end
   end

   // Each response word is held against the oldest verdict still due.
   always @(posedge clock) begin : verdict_check
      check_result_type seen;
      check_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.ready_cycle = rsp_tdata[READY_BITS-1:0];
         seen.issued      = rsp_tuser[0];
         seen.bad_command = rsp_tuser[1];
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("response word with none due: ready %0d issued %0b bad %0b",
                        seen.ready_cycle, seen.issued, seen.bad_command);
         end else begin
            want = verdicts_due.pop_front();
            if (seen.ready_cycle !== want.ready_cycle || seen.issued !== want.issued ||
                seen.bad_command !== want.bad_command) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"mismatch: expected ready %0d issued %0b bad %0b,",
                            " got ready %0d issued %0b bad %0b"},
                           want.ready_cycle, want.issued, want.bad_command,
                           seen.ready_cycle, seen.issued, seen.bad_command);
            end
         end
      end
   end

   // Guard against a hung handshake.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
